// ===== design/sfs_pkg.sv =====
package sfs_pkg;

  localparam int AccW    = 17;
  localparam int PsumW   = 18;
  localparam int LinW    = 22;
  localparam int DvdW    = LinW;
  localparam int DvsW    = 16;
  localparam int DivCntW = $clog2(DvdW + 1);
  localparam int MulW    = 11;
  localparam int MulCntW = $clog2(MulW);
  localparam int FrameW  = 11;
  localparam int RlDiffW = 20;

  localparam logic [8:0]  RepeatForever = 9'h1FF;
  localparam logic [8:0]  RepeatFloor   = 9'h100;
  localparam logic [12:0] TexWidthMax   = 13'd4096;

  typedef enum logic [2:0] {
    CFG_FRAME_WIDTH   = 3'd0,
    CFG_FRAME_HEIGHT  = 3'd1,
    CFG_TEXTURE_WIDTH = 3'd2,
    CFG_FRAME_DELAY   = 3'd3,
    CFG_FIRST_FRAME   = 3'd4,
    CFG_FRAME_COUNT   = 3'd5,
    CFG_REPEAT_TIMES  = 3'd6
  } sfs_cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TDIV,
    ST_PDIV,
    ST_XMUL,
    ST_XDIV,
    ST_YMUL,
    ST_HOLD
  } sfs_state_e;

  typedef struct packed {
    logic               start;
    logic [DivCntW-1:0] nbits;
  } sfs_div_ctl_t;

endpackage

// ===== design/sprite_frame_sequencer.sv =====
// Items are not overlapped: the input stalls from transfer until the result has moved
// to the output register. The two timing divisions are skipped when the animation
// is frozen or has fewer than two frames. Each item's arithmetic uses the shared
// one-bit-per-cycle divider (17, 18 and 22 steps) and two 11-step serial multiplies.
// A finished result waits in the output register while the next item is taken.
// Reset: asynchronous, active low; control and config registers load their defaults, animation restarts.
module sprite_frame_sequencer #(
  parameter int MAX_FRAMES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] elapsed_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [10:0] frame_index_o,
  output logic [11:0] src_x_o,
  output logic [15:0] src_y_o,
  output logic        finished_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import sfs_pkg::*;

  localparam int CntMax = (MAX_FRAMES < 127) ? MAX_FRAMES : 127;
  localparam int PosW   = (CntMax > 1) ? $clog2(CntMax) : 1;

  sfs_state_e state_q, state_d;

  logic [10:0] frame_width_q, frame_height_q;
  logic [12:0] texture_width_q;
  logic [15:0] frame_delay_q;
  logic [9:0]  first_frame_q;
  logic [6:0]  frame_count_q;
  logic [8:0]  repeat_times_q;

  logic [15:0]     time_accum_q;
  logic [PosW-1:0] frame_pos_q;
  logic [8:0]      repeats_left_q;
  logic            done_q;

  logic [MulCntW-1:0] mcnt_q;
  logic [15:0]        tacc_q;
  logic [FrameW-1:0]  frame_q;
  logic [MulW-1:0]    mop_q;
  logic [LinW-1:0]    lin_q, lin_d;
  logic [11:0]        sx_q;
  logic [LinW-1:0]    qy_q;
  logic [15:0]        yacc_q, yacc_d;
  logic               ysat_q, ysat_d;

  logic              out_valid_q;
  logic [10:0]       out_frame_q;
  logic [11:0]       out_sx_q;
  logic [15:0]       out_sy_q;
  logic              out_fin_q;

  sfs_div_ctl_t  div_ctl;
  logic [DvdW-1:0] div_dividend, div_quo;
  logic [DvsW-1:0] div_divisor, div_rem;
  logic            div_done;

  logic              in_xfer, out_free, cfg_we, restart;
  logic [6:0]        cnt_eff;
  logic              short_anim;
  logic [15:0]       delay_eff;
  logic [12:0]       tw_eff;
  logic [FrameW-1:0] last_frame, still_frame, frame_new;
  logic [AccW-1:0]   acc_sum;
  logic [PsumW-1:0]  pos_sum, wraps;
  logic [PosW-1:0]   pos_rem;
  logic signed [RlDiffW-1:0] rl_diff;
  logic [8:0]        rl_new;
  logic              update_rl, freeze;
  logic [17:0]       ysum;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign restart     = cfg_we && (cfg_index_i inside {CFG_FRAME_DELAY, CFG_FIRST_FRAME,
                                                      CFG_FRAME_COUNT, CFG_REPEAT_TIMES});
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    cnt_eff     = (frame_count_q > 7'(CntMax)) ? 7'(CntMax) : frame_count_q;
    short_anim  = cnt_eff < 7'd2;
    delay_eff   = (frame_delay_q == '0) ? 16'd1 : frame_delay_q;
    if (texture_width_q == '0) begin
      tw_eff = 13'd1;
    end else if (texture_width_q > TexWidthMax) begin
      tw_eff = TexWidthMax;
    end else begin
      tw_eff = texture_width_q;
    end
    last_frame  = {1'b0, first_frame_q} + {4'b0, cnt_eff} - 11'd1;
    still_frame = short_anim ? {1'b0, first_frame_q} : last_frame;
    acc_sum     = {1'b0, time_accum_q} + {1'b0, elapsed_i};
    pos_sum     = PsumW'(frame_pos_q) + {1'b0, div_quo[AccW-1:0]};
    wraps       = div_quo[PsumW-1:0];
    pos_rem     = div_rem[PosW-1:0];
    rl_diff     = $signed({{(RlDiffW-9){repeats_left_q[8]}}, repeats_left_q})
                - $signed({2'b00, wraps});
    rl_new      = (rl_diff < -20'sd256) ? RepeatFloor : rl_diff[8:0];
    update_rl   = (wraps != '0) && (repeats_left_q != RepeatForever);
    freeze      = update_rl && (rl_new[8] || (rl_new == '0));
    frame_new   = freeze ? last_frame : ({1'b0, first_frame_q} + FrameW'(pos_rem));
    lin_d       = {lin_q[LinW-2:0], 1'b0} + (mop_q[MulW-1] ? LinW'(frame_width_q) : '0);
    ysum        = {1'b0, yacc_q, 1'b0} + (mop_q[MulW-1] ? {2'b00, qy_q[15:0]} : 18'd0);
    ysat_d      = ysat_q || (mop_q[MulW-1] && (qy_q[LinW-1:16] != '0)) || (ysum[17:16] != '0);
    yacc_d      = ysum[15:0];
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_xfer) state_d = (short_anim || done_q) ? ST_XMUL : ST_TDIV;
      ST_TDIV: if (div_done) state_d = ST_PDIV;
      ST_PDIV: if (div_done) state_d = ST_XMUL;
      ST_XMUL: if (mcnt_q == '0) state_d = ST_XDIV;
      ST_XDIV: if (div_done) state_d = ST_YMUL;
      ST_YMUL: if (mcnt_q == '0) state_d = ST_HOLD;
      ST_HOLD: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // divider requests
  always_comb begin
    div_ctl      = '0;
    div_dividend = '0;
    div_divisor  = '0;
    case (state_q)
      ST_IDLE: begin
        div_ctl.start = in_xfer && !short_anim && !done_q;
        div_ctl.nbits = DivCntW'(AccW);
        div_dividend  = {acc_sum, {(DvdW-AccW){1'b0}}};
        div_divisor   = delay_eff;
      end
      ST_TDIV: begin
        div_ctl.start = div_done;
        div_ctl.nbits = DivCntW'(PsumW);
        div_dividend  = {pos_sum, {(DvdW-PsumW){1'b0}}};
        div_divisor   = DvsW'(cnt_eff);
      end
      ST_XMUL: begin
        div_ctl.start = (mcnt_q == '0);
        div_ctl.nbits = DivCntW'(LinW);
        div_dividend  = lin_d;
        div_divisor   = DvsW'(tw_eff);
      end
      default: begin
        div_ctl = '0;
      end
    endcase
  end

  sfs_sdiv u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (div_ctl),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      mcnt_q          <= '0;
      out_valid_q     <= 1'b0;
      frame_width_q   <= 11'd16;
      frame_height_q  <= 11'd16;
      texture_width_q <= 13'd256;
      frame_delay_q   <= 16'd1;
      first_frame_q   <= 10'd0;
      frame_count_q   <= 7'd1;
      repeat_times_q  <= RepeatForever;
      time_accum_q    <= '0;
      frame_pos_q     <= '0;
      repeats_left_q  <= RepeatForever;
      done_q          <= 1'b0;
    end else begin
      state_q <= state_d;

      if ((state_q == ST_IDLE && in_xfer && (short_anim || done_q)) ||
          (state_q == ST_PDIV && div_done) || (state_q == ST_XDIV && div_done)) begin
        mcnt_q <= MulCntW'(MulW - 1);
      end else if ((state_q == ST_XMUL || state_q == ST_YMUL) && mcnt_q != '0) begin
        mcnt_q <= mcnt_q - MulCntW'(1);
      end

      if (state_q == ST_HOLD && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_index_i)
          CFG_FRAME_WIDTH:   frame_width_q   <= cfg_data_i[10:0];
          CFG_FRAME_HEIGHT:  frame_height_q  <= cfg_data_i[10:0];
          CFG_TEXTURE_WIDTH: texture_width_q <= cfg_data_i[12:0];
          CFG_FRAME_DELAY:   frame_delay_q   <= cfg_data_i;
          CFG_FIRST_FRAME:   first_frame_q   <= cfg_data_i[9:0];
          CFG_FRAME_COUNT:   frame_count_q   <= cfg_data_i[6:0];
          CFG_REPEAT_TIMES:  repeat_times_q  <= cfg_data_i[8:0];
          default: ;
        endcase
      end

      if (restart) begin
        time_accum_q   <= '0;
        frame_pos_q    <= '0;
        done_q         <= 1'b0;
        repeats_left_q <= (cfg_index_i == CFG_REPEAT_TIMES) ? cfg_data_i[8:0] : repeat_times_q;
      end else if (state_q == ST_PDIV && div_done) begin
        if (update_rl) repeats_left_q <= rl_new;
        if (freeze) begin
          done_q       <= 1'b1;
          time_accum_q <= '0;
          frame_pos_q  <= '0;
        end else begin
          time_accum_q <= tacc_q;
          frame_pos_q  <= pos_rem;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && (short_anim || done_q)) begin
          frame_q <= still_frame;
          mop_q   <= still_frame;
          lin_q   <= '0;
        end
      end
      ST_TDIV: begin
        if (div_done) tacc_q <= div_rem;
      end
      ST_PDIV: begin
        if (div_done) begin
          frame_q <= frame_new;
          mop_q   <= frame_new;
          lin_q   <= '0;
        end
      end
      ST_XMUL: begin
        lin_q <= lin_d;
        mop_q <= {mop_q[MulW-2:0], 1'b0};
      end
      ST_XDIV: begin
        if (div_done) begin
          sx_q   <= div_rem[11:0];
          qy_q   <= div_quo;
          mop_q  <= frame_height_q;
          yacc_q <= '0;
          ysat_q <= 1'b0;
        end
      end
      ST_YMUL: begin
        yacc_q <= yacc_d;
        ysat_q <= ysat_d;
        mop_q  <= {mop_q[MulW-2:0], 1'b0};
      end
      ST_HOLD: begin
        if (out_free) begin
          out_frame_q <= frame_q;
          out_sx_q    <= sx_q;
          out_sy_q    <= ysat_q ? 16'hFFFF : yacc_q;
          out_fin_q   <= done_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign frame_index_o = out_frame_q;
  assign src_x_o       = out_sx_q;
  assign src_y_o       = out_sy_q;
  assign finished_o    = out_fin_q;

endmodule

// ===== design/sfs_sdiv.sv =====
module sfs_sdiv (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sfs_pkg::sfs_div_ctl_t        ctl_i,
  input  logic [sfs_pkg::DvdW-1:0]     dividend_i,
  input  logic [sfs_pkg::DvsW-1:0]     divisor_i,
  output logic                         done_o,
  output logic [sfs_pkg::DvdW-1:0]     quotient_o,
  output logic [sfs_pkg::DvsW-1:0]     remainder_o
);
  import sfs_pkg::*;

  logic               busy_q, done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DvdW-1:0]    dvd_q, quo_q;
  logic [DvsW-1:0]    dvs_q, rem_q;
  logic [DvsW:0]      trial;
  logic               fits;
  logic [DvsW-1:0]    rem_step;

  // restoring division, dividend arrives left-aligned, one quotient bit per cycle
  always_comb begin
    trial    = {rem_q, dvd_q[DvdW-1]};
    fits     = trial >= {1'b0, dvs_q};
    rem_step = fits ? DvsW'(trial - {1'b0, dvs_q}) : trial[DvsW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= ctl_i.nbits;
      end else if (busy_q) begin
        cnt_q <= cnt_q - DivCntW'(1);
        if (cnt_q == DivCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DvdW-2:0], 1'b0};
      rem_q <= rem_step;
      quo_q <= {quo_q[DvdW-2:0], fits};
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ===== design/sfs_chk.sv =====
module sfs_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [10:0] frame_index_o,
  input logic [11:0] src_x_o,
  input logic [15:0] src_y_o,
  input logic        finished_o
);

  // one item in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while previous item still in work");

  // a new result only follows work in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without an item in work");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> ($stable(frame_index_o) && $stable(src_x_o) &&
                                      $stable(src_y_o) && $stable(finished_o)))
    else $error("stalled result changed");

endmodule

bind sprite_frame_sequencer sfs_chk u_sfs_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .frame_index_o (frame_index_o),
  .src_x_o       (src_x_o),
  .src_y_o       (src_y_o),
  .finished_o    (finished_o)
);
